// File: hdl/pcht_pkg.sv
// shared types, constants and helpers for the pair count hash table
`default_nettype none

package pcht_pkg;

   // table geometry defaults
   localparam int unsigned SLOTS_DEF  = 1024;
   localparam int unsigned TOKEN_BITS = 24;
   localparam int unsigned KEY_W      = 2 * TOKEN_BITS;

   // fmix64 multiplier constants
   localparam logic [63:0] MIX_C1 = 64'hFF51AFD7ED558CCD;
   localparam logic [63:0] MIX_C2 = 64'hC4CEB9FE1A85EC53;

   // request operation codes
   localparam logic [1:0] FUNC_ADD   = 2'd0;
   localparam logic [1:0] FUNC_BEST  = 2'd1;
   localparam logic [1:0] FUNC_CLEAR = 2'd2;

   // response status codes
   localparam logic [2:0] STAT_UPDATED  = 3'd0;
   localparam logic [2:0] STAT_INSERTED = 3'd1;
   localparam logic [2:0] STAT_FULL     = 3'd2;
   localparam logic [2:0] STAT_BEST     = 3'd3;
   localparam logic [2:0] STAT_NOBEST   = 3'd4;

   // partial product steps of one 64-bit multiply
   typedef enum logic [1:0] {
      MUL_LL,
      MUL_HL,
      MUL_LH,
      MUL_ACC
   } mul_phase_type;

   // which result the datapath stages
   typedef enum logic [2:0] {
      RES_UPDATE,
      RES_INSERT,
      RES_FULL,
      RES_BEST,
      RES_CLEAR,
      RES_NOBEST
   } res_sel_type;

   // commands from controller to datapath
   typedef struct packed {
      logic          load_req;
      logic          mul_en;
      mul_phase_type mul_phase;
      logic          mul_round;
      logic          mix_en;
      logic          idx_load;
      logic          rd_probe;
      logic          probe_next;
      logic          wr_update;
      logic          wr_insert;
      logic          sweep_start;
      logic          scan_rd;
      logic          clr_wr;
      logic          total_clr;
      logic          res_en;
      res_sel_type   res_sel;
      logic          out_load;
   } ctl_type;

   // status from datapath to controller
   typedef struct packed {
      logic hit;
      logic empty;
      logic full;
      logic sweep_done;
   } sts_type;

   // murmur3 finalizer xor-shift
   function automatic logic [63:0] mix64(input logic [63:0] x);
      return x ^ (x >> 33);
   endfunction

endpackage

`default_nettype wire

// File: hdl/pcht_dp.sv
// datapath: hash unit, slot memory, probe and scan logic, result registers
`default_nettype none

module pcht_dp #(
   parameter int unsigned SLOTS = pcht_pkg::SLOTS_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire pcht_pkg::ctl_type                    ctl,
   output pcht_pkg::sts_type                         sts,
   input  wire logic [pcht_pkg::TOKEN_BITS-1:0]      req_left_token,
   input  wire logic [pcht_pkg::TOKEN_BITS-1:0]      req_right_token,
   input  wire logic signed [15:0]                   req_increment,
   output logic [2:0]                                rsp_status,
   output logic [pcht_pkg::TOKEN_BITS-1:0]           rsp_best_left,
   output logic [pcht_pkg::TOKEN_BITS-1:0]           rsp_best_right,
   output logic signed [31:0]                        rsp_best_count,
   output logic [$clog2(SLOTS):0]                    rsp_occupied
);
   import pcht_pkg::*;

   localparam int unsigned IDX_W = $clog2(SLOTS);
   localparam int unsigned CNT_W = IDX_W + 1;

   typedef struct packed {
      logic               valid;
      logic [KEY_W-1:0]   key;
      logic signed [31:0] count;
   } entry_type;

   entry_type mem [SLOTS];
   entry_type rd_ff;

   logic [KEY_W-1:0]        key_ff;
   logic signed [15:0]      inc_ff;
   logic [63:0]             h_ff, acc_ff, mul_ff;
   logic [IDX_W-1:0]        idx_ff;
   logic [CNT_W-1:0]        ptr_ff, total_ff;
   logic                    cmp_ff, have_ff;
   logic [KEY_W-1:0]        bkey_ff;
   logic signed [31:0]      bcnt_ff;
   logic [2:0]              res_status_ff, res_status_in;
   logic [TOKEN_BITS-1:0]   res_left_ff, res_right_ff;
   logic [TOKEN_BITS-1:0]   res_left_in, res_right_in;
   logic signed [31:0]      res_count_ff, res_count_in;

   logic [31:0]             mul_a, mul_b;
   logic [63:0]             mix_acc;
   logic [32:0]             sum;
   logic signed [31:0]      sat, inc_ext;
   logic signed [31:0]      cand;
   logic                    better;
   logic                    wr_en, rd_en;
   logic [IDX_W-1:0]        wr_addr, rd_addr;
   entry_type               wr_data;

   // partial product operand selection
   always_comb begin
      logic [63:0] c;
      c = ctl.mul_round ? MIX_C2 : MIX_C1;
      mul_a = (ctl.mul_phase == MUL_HL) ? h_ff[63:32] : h_ff[31:0];
      mul_b = (ctl.mul_phase == MUL_LH) ? c[63:32] : c[31:0];
   end

   assign mix_acc = mix64(acc_ff);

   // saturating count update
   assign inc_ext = 32'(inc_ff);
   assign sum     = {rd_ff.count[31], rd_ff.count} + {inc_ext[31], inc_ext};
   always_comb begin
      if (sum[32] != sum[31]) begin
         sat = sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
         sat = $signed(sum[31:0]);
      end
   end

   // best candidate compare
   assign cand   = rd_ff.count;
   assign better = rd_ff.valid && (cand > 0) &&
                   (!have_ff || cand > bcnt_ff || (cand == bcnt_ff && rd_ff.key < bkey_ff));

   // memory port muxing
   assign wr_en   = ctl.wr_update | ctl.wr_insert | ctl.clr_wr;
   assign wr_addr = ctl.clr_wr ? ptr_ff[IDX_W-1:0] : idx_ff;
   assign rd_en   = ctl.rd_probe | ctl.scan_rd;
   assign rd_addr = ctl.scan_rd ? ptr_ff[IDX_W-1:0] : idx_ff;
   always_comb begin
      wr_data = '0;
      if (ctl.wr_update) begin
         wr_data = '{valid: 1'b1, key: key_ff, count: sat};
      end else if (ctl.wr_insert) begin
         wr_data = '{valid: 1'b1, key: key_ff, count: inc_ext};
      end
   end

   // slot memory
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

   // status back to controller
   assign sts.hit        = rd_ff.valid && (rd_ff.key == key_ff);
   assign sts.empty      = !rd_ff.valid;
   assign sts.full       = total_ff >= CNT_W'(SLOTS / 2);
   assign sts.sweep_done = ptr_ff == CNT_W'(SLOTS);

   // control counters
   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff   <= '0;
         total_ff <= '0;
         cmp_ff   <= 1'b0;
         have_ff  <= 1'b0;
      end else begin
         cmp_ff <= ctl.scan_rd;
         if (ctl.sweep_start) begin
            ptr_ff  <= '0;
            have_ff <= 1'b0;
         end else if (ctl.scan_rd || ctl.clr_wr) begin
            ptr_ff <= ptr_ff + 1'b1;
         end
         if (cmp_ff && better) begin
            have_ff <= 1'b1;
         end
         if (ctl.total_clr) begin
            total_ff <= '0;
         end else if (ctl.wr_insert) begin
            total_ff <= total_ff + 1'b1;
         end
      end
   end

   // hash, probe and best payload registers
   always_ff @(posedge clock) begin
      if (ctl.load_req) begin
         key_ff <= {req_left_token, req_right_token};
         inc_ff <= req_increment;
         h_ff   <= mix64({32'(req_left_token), 32'(req_right_token)});
      end else if (ctl.mix_en) begin
         h_ff <= mix_acc;
      end
      if (ctl.mul_en) begin
         mul_ff <= 64'(mul_a) * 64'(mul_b);
         unique case (ctl.mul_phase)
            MUL_LL:  acc_ff <= acc_ff;
            MUL_HL:  acc_ff <= mul_ff;
            default: acc_ff <= acc_ff + {mul_ff[31:0], 32'd0};
         endcase
      end
      if (ctl.idx_load) begin
         idx_ff <= mix_acc[IDX_W-1:0];
      end else if (ctl.probe_next) begin
         idx_ff <= idx_ff + 1'b1;
      end
      if (cmp_ff && better) begin
         bkey_ff <= rd_ff.key;
         bcnt_ff <= cand;
      end
   end

   // result selection
   always_comb begin
      res_status_in = STAT_NOBEST;
      res_left_in   = '0;
      res_right_in  = '0;
      res_count_in  = '0;
      unique case (ctl.res_sel)
         RES_UPDATE: begin
            res_status_in = STAT_UPDATED;
            res_count_in  = sat;
         end
         RES_INSERT: begin
            res_status_in = STAT_INSERTED;
            res_count_in  = inc_ext;
         end
         RES_FULL:   res_status_in = STAT_FULL;
         RES_BEST: begin
            if (have_ff) begin
               res_status_in = STAT_BEST;
               res_left_in   = bkey_ff[KEY_W-1:TOKEN_BITS];
               res_right_in  = bkey_ff[TOKEN_BITS-1:0];
               res_count_in  = bcnt_ff;
            end
         end
         RES_CLEAR:  res_status_in = STAT_UPDATED;
         default:    res_status_in = STAT_NOBEST;
      endcase
   end

   // result staging and output register
   always_ff @(posedge clock) begin
      if (ctl.res_en) begin
         res_status_ff <= res_status_in;
         res_left_ff   <= res_left_in;
         res_right_ff  <= res_right_in;
         res_count_ff  <= res_count_in;
      end
      if (ctl.out_load) begin
         rsp_status     <= res_status_ff;
         rsp_best_left  <= res_left_ff;
         rsp_best_right <= res_right_ff;
         rsp_best_count <= res_count_ff;
         rsp_occupied   <= total_ff;
      end
   end

endmodule

`default_nettype wire

// File: hdl/pcht_ctrl.sv
// controller: sequences hashing, probing, scans, clears and the response beat
`default_nettype none

module pcht_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [1:0]        req_func,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output pcht_pkg::ctl_type      ctl,
   input  wire pcht_pkg::sts_type sts
);
   import pcht_pkg::*;

   typedef enum logic [3:0] {
      S_INIT,
      S_IDLE,
      S_HASH,
      S_MIX,
      S_PROBE_RD,
      S_PROBE_CHK,
      S_SCAN,
      S_SCAN_TAIL,
      S_BEST_FIN,
      S_CLEAR,
      S_RESP
   } state_type;

   state_type     state_ff, state_in;
   mul_phase_type mstep_ff, mstep_in;
   logic          round_ff, round_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          accept, out_free;

   assign accept    = (state_ff == S_IDLE) && req_valid;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = state_ff == S_IDLE;
   assign rsp_valid = rsp_valid_ff;

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      mstep_in     = mstep_ff;
      round_in     = round_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      ctl          = '0;
      ctl.mul_phase = mstep_ff;
      ctl.mul_round = round_ff;
      ctl.res_sel   = RES_NOBEST;
      unique case (state_ff)
         S_INIT: begin
            ctl.clr_wr = !sts.sweep_done;
            if (sts.sweep_done) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (accept) begin
               unique case (req_func)
                  FUNC_ADD: begin
                     ctl.load_req = 1'b1;
                     mstep_in     = MUL_LL;
                     round_in     = 1'b0;
                     state_in     = S_HASH;
                  end
                  FUNC_BEST: begin
                     ctl.sweep_start = 1'b1;
                     state_in        = S_SCAN;
                  end
                  FUNC_CLEAR: begin
                     ctl.sweep_start = 1'b1;
                     ctl.total_clr   = 1'b1;
                     ctl.res_en      = 1'b1;
                     ctl.res_sel     = RES_CLEAR;
                     state_in        = S_CLEAR;
                  end
                  default: begin
                     ctl.res_en  = 1'b1;
                     ctl.res_sel = RES_NOBEST;
                     state_in    = S_RESP;
                  end
               endcase
            end
         end
         S_HASH: begin
            ctl.mul_en = 1'b1;
            mstep_in   = mul_phase_type'(mstep_ff + 2'd1);
            if (mstep_ff == MUL_ACC) state_in = S_MIX;
         end
         S_MIX: begin
            if (round_ff) begin
               ctl.idx_load = 1'b1;
               state_in     = S_PROBE_RD;
            end else begin
               ctl.mix_en = 1'b1;
               round_in   = 1'b1;
               state_in   = S_HASH;
            end
         end
         S_PROBE_RD: begin
            ctl.rd_probe = 1'b1;
            state_in     = S_PROBE_CHK;
         end
         S_PROBE_CHK: begin
            if (sts.hit) begin
               ctl.wr_update = 1'b1;
               ctl.res_en    = 1'b1;
               ctl.res_sel   = RES_UPDATE;
               state_in      = S_RESP;
            end else if (sts.empty) begin
               ctl.res_en = 1'b1;
               if (sts.full) begin
                  ctl.res_sel = RES_FULL;
               end else begin
                  ctl.wr_insert = 1'b1;
                  ctl.res_sel   = RES_INSERT;
               end
               state_in = S_RESP;
            end else begin
               ctl.probe_next = 1'b1;
               state_in       = S_PROBE_RD;
            end
         end
         S_SCAN: begin
            ctl.scan_rd = !sts.sweep_done;
            if (sts.sweep_done) state_in = S_SCAN_TAIL;
         end
         S_SCAN_TAIL: state_in = S_BEST_FIN;
         S_BEST_FIN: begin
            ctl.res_en  = 1'b1;
            ctl.res_sel = RES_BEST;
            state_in    = S_RESP;
         end
         S_CLEAR: begin
            ctl.clr_wr = !sts.sweep_done;
            if (sts.sweep_done) state_in = S_RESP;
         end
         S_RESP: begin
            if (out_free) begin
               ctl.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         mstep_ff     <= MUL_LL;
         round_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mstep_ff     <= mstep_in;
         round_ff     <= round_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

// File: hdl/pair_count_hash_table.sv
// top level of the pair count hash table
//
// Request channel (req_*): func selects add (0), best (1) or clear (2);
// left/right tokens and a signed increment are used by add. Each request
// beat produces exactly one response beat on rsp_*, carrying status, the
// best pair or zeros, a count and the number of occupied slots.
// Add: two fmix64 multiply rounds on one 32x32 multiplier, then a probe
// of the slot memory per slot, a read state and then a check state, until
// a hit updates the count or an empty slot takes the insert (or answers full).
// Best and clear sweep every slot, one a cycle.
// One request is in flight at a time; req_ready is high only when idle.
// The response sits in an output register, so the next request is taken
// and worked on while a response still waits for rsp_ready; a stalled
// receiver only holds the next completion.
// After reset the block sweeps the memory empty with req_ready low.
// Inserts beyond SLOTS/2 entries answer status full.
`default_nettype none

module pair_count_hash_table #(
   parameter int unsigned SLOTS = pcht_pkg::SLOTS_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic [1:0]                       req_func,
   input  wire logic [pcht_pkg::TOKEN_BITS-1:0]  req_left_token,
   input  wire logic [pcht_pkg::TOKEN_BITS-1:0]  req_right_token,
   input  wire logic signed [15:0]               req_increment,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic [2:0]                            rsp_status,
   output logic [pcht_pkg::TOKEN_BITS-1:0]       rsp_best_left,
   output logic [pcht_pkg::TOKEN_BITS-1:0]       rsp_best_right,
   output logic signed [31:0]                    rsp_best_count,
   output logic [$clog2(SLOTS):0]                rsp_occupied
);
   import pcht_pkg::*;

   ctl_type ctl;
   sts_type sts;

   pcht_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_func  (req_func),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .ctl       (ctl),
      .sts       (sts)
   );

   pcht_dp #(.SLOTS(SLOTS)) u_dp (
      .clock           (clock),
      .reset           (reset),
      .ctl             (ctl),
      .sts             (sts),
      .req_left_token  (req_left_token),
      .req_right_token (req_right_token),
      .req_increment   (req_increment),
      .rsp_status      (rsp_status),
      .rsp_best_left   (rsp_best_left),
      .rsp_best_right  (rsp_best_right),
      .rsp_best_count  (rsp_best_count),
      .rsp_occupied    (rsp_occupied)
   );

   // one request in flight: ready drops after each accepted beat
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while busy");

   // the table never fills past half
   a_half_load: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_occupied <= ($clog2(SLOTS) + 1)'(SLOTS / 2))
      else $error("occupancy above half the slots");

   // a refused insert reports a zero count and no pair
   a_full_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STAT_FULL |->
         rsp_best_count == 0 && rsp_best_left == 0 && rsp_best_right == 0)
      else $error("full response carries data");

endmodule

`default_nettype wire
